@@ hw/rtl/lfwe_pkg.sv @@
// ----------------------------------------------------------------------------
// lfwe_pkg
// Shared types and constants of the lot queue engine.
// ----------------------------------------------------------------------------
package lfwe_pkg;
	localparam int DepthDefault = 16;
	localparam int StepW  = 20;
	localparam int AmtW   = 40;
	localparam int AgeW   = 37;
	localparam int OlderW = 44;
	localparam int ReqW   = 3;
	localparam int ProdW  = AmtW + StepW;   // 60-bit amount x age
	localparam int AccW   = 72;             // signed weighted age sum
	localparam int NumW   = 96;             // magnitude shifted by 16
	localparam int TotW   = 50;             // total amount, headroom to DEPTH 1024

	typedef enum logic [ReqW-1:0] {
		REQ_PUSH     = 3'd0,
		REQ_WITHDRAW = 3'd1,
		REQ_AVERAGE  = 3'd2,
		REQ_OLDER    = 3'd3,
		REQ_CLEAR    = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		DP_NONE, DP_START, DP_PUSH, DP_WALK, DP_DIV_START, DP_DIV, DP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] req;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic div_done;
		logic div_zero;
	} dp_stat_t;
endpackage

@@ hw/rtl/lot_fifo_withdraw_engine.sv @@
// Withdraw walks the lots it touches; amount-older and average age walk every lot
// held, and average age then runs a bit-serial 96-bit divide, skipped when the
// total is zero. One request in flight; the lot walk (one ring entry per fetch
// and process step through a registered read) and the divider set the rate.
// Reset empties the ring; lot storage is not cleared.
// ----------------------------------------------------------------------------
// lot_fifo_withdraw_engine
// FIFO lot queue: push, oldest-first withdraw, weighted age and age sums.
// ----------------------------------------------------------------------------
module lot_fifo_withdraw_engine #(
	parameter int DEPTH = lfwe_pkg::DepthDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,  // [19:0] step, [59:20] amount, zero pad
	input  logic [2:0]   s_tuser,  // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	// [39:0] amount_taken, [76:40] average_age, [120:77] amount_older,
	// [125:121] lots_held, [126] push_dropped, zero pad
	output logic [127:0] m_tdata
);
	import lfwe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy;
	logic     in_fire;
	logic     out_fire;
	logic [AmtW-1:0]   taken;
	logic [AgeW-1:0]   age;
	logic [OlderW-1:0] older;
	logic [$clog2(DEPTH+1)-1:0] held;
	logic dropped;

	// take a new transaction only when the sequencer is idle
	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	lfwe_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_req(s_tuser), .out_fire, .stat, .cmd, .busy,
		.res_valid(m_tvalid)
	);

	lfwe_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .in_step(s_tdata[19:0]), .in_amount(s_tdata[59:20]),
		.stat, .amount_taken(taken), .average_age(age), .amount_older(older),
		.lots_held(held), .push_dropped(dropped)
	);

	// hold the result in the datapath registers until the transaction is taken
	assign m_tdata = {1'b0, dropped, 5'(held), older, age, taken};
endmodule

@@ hw/rtl/lfwe_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfwe_ctrl
// Sequencer: steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module lfwe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic [2:0]         in_req,
	input  logic               out_fire,
	input  lfwe_pkg::dp_stat_t stat,
	output lfwe_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               res_valid
);
	import lfwe_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_WALK, S_DIVS, S_DIV, S_DONE} state_t;
	state_t     state_q;
	logic [2:0] req_q;

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		cmd.req = req_q;
		cmd.op  = DP_NONE;
		case (state_q)
			S_IDLE: if (in_fire) begin
				cmd.req = in_req;
				cmd.op  = DP_START;
			end
			S_WALK: cmd.op = DP_WALK;
			S_DIVS: cmd.op = DP_DIV_START;
			S_DIV:  cmd.op = DP_DIV;
			default: cmd.op = DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					req_q <= in_req;
					if (in_req == REQ_WITHDRAW || in_req == REQ_AVERAGE ||
					    in_req == REQ_OLDER)
						state_q <= S_WALK;
					else
						state_q <= S_DONE;
				end
				S_WALK: if (stat.walk_done) begin
					if (req_q == REQ_AVERAGE)
						state_q <= S_DIVS;
					else
						state_q <= S_DONE;
				end
				S_DIVS: state_q <= stat.div_zero ? S_DONE : S_DIV;
				S_DIV:  if (stat.div_done) state_q <= S_DONE;
				S_DONE: if (out_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/lfwe_datapath.sv @@
// ----------------------------------------------------------------------------
// lfwe_datapath
// Lot ring memory, walk accumulators and a restoring divider.
// ----------------------------------------------------------------------------
module lfwe_datapath #(
	parameter int DEPTH = lfwe_pkg::DepthDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lfwe_pkg::dp_cmd_t           cmd,
	input  logic [lfwe_pkg::StepW-1:0]  in_step,
	input  logic [lfwe_pkg::AmtW-1:0]   in_amount,
	output lfwe_pkg::dp_stat_t          stat,
	output logic [lfwe_pkg::AmtW-1:0]   amount_taken,
	output logic [lfwe_pkg::AgeW-1:0]   average_age,
	output logic [lfwe_pkg::OlderW-1:0] amount_older,
	output logic [$clog2(DEPTH+1)-1:0]  lots_held,
	output logic                        push_dropped
);
	import lfwe_pkg::*;

	localparam int IdxW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH+1);
	localparam int DivCntW = $clog2(NumW+1);

	logic [StepW-1:0] step_mem [DEPTH];
	logic [AmtW-1:0]  amt_mem  [DEPTH];

	logic [IdxW-1:0] oldest_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] k_q;
	logic [StepW-1:0] arg_step_q;
	logic [AmtW-1:0]  left_q;
	logic [AmtW-1:0]  want_q;
	logic [2:0]       req_q;
	logic [AccW-1:0]  acc_q;
	logic [TotW-1:0]  tot_q;
	logic [OlderW-1:0] older_q;
	logic              first_ok_q;
	logic              ph_q;
	logic [AmtW-1:0]  rd_amt_q;
	logic [StepW-1:0] rd_step_q;
	logic [IdxW-1:0]  rd_slot;
	logic [IdxW-1:0]  wr_slot;
	logic              walk_end;
	// divider
	logic [NumW-1:0]   num_q;
	logic [NumW:0]     rem_q;
	logic              neg_q;
	logic [DivCntW-1:0] dcnt_q;
	logic [NumW:0]     rem_sh;
	logic [NumW:0]     rem_sub;
	logic [AgeW-1:0]   q_trunc;
	logic              older_sat;
	logic [OlderW:0]   older_sum;
	logic [ProdW-1:0]  prod;
	logic [StepW-1:0]  age_mag;
	logic              age_neg;
	logic [AccW-1:0]   acc_mag;

	always_comb begin
		logic [IdxW:0] s;
		s = {1'b0, oldest_q} + {1'b0, k_q[IdxW-1:0]};
		if (s >= (IdxW+1)'(DEPTH)) s = s - (IdxW+1)'(DEPTH);
		rd_slot = s[IdxW-1:0];
		s = {1'b0, oldest_q} + {1'b0, count_q[IdxW-1:0]};
		if (s >= (IdxW+1)'(DEPTH)) s = s - (IdxW+1)'(DEPTH);
		wr_slot = s[IdxW-1:0];
	end

	assign age_neg = rd_step_q > arg_step_q;
	assign age_mag = age_neg ? rd_step_q - arg_step_q : arg_step_q - rd_step_q;
	assign prod    = ProdW'(rd_amt_q) * ProdW'(age_mag);
	assign older_sum = {1'b0, older_q} + (OlderW+1)'(rd_amt_q);
	assign older_sat = older_sum[OlderW];

	// withdraw walks oldest only (k stays 0); sums walk k over count
	always_comb begin
		case (req_q)
			REQ_WITHDRAW: walk_end = (left_q == '0) || (count_q == '0);
			default:      walk_end = (k_q == count_q);
		endcase
	end

	assign acc_mag = acc_q[AccW-1] ? (~acc_q + 1'b1) : acc_q;
	assign rem_sh  = {rem_q[NumW-1:0], num_q[NumW-1]};
	assign rem_sub = rem_sh - (NumW+1)'(tot_q);
	assign q_trunc = num_q[AgeW-1:0];

	// each walk step is a fetch phase followed by a process phase
	assign stat.walk_done = ph_q && walk_end;
	assign stat.div_done  = (dcnt_q == '0);
	assign stat.div_zero  = (tot_q == '0);

	always_ff @(posedge clk) begin
		rd_step_q <= step_mem[rd_slot];
		rd_amt_q  <= amt_mem[rd_slot];
		if (cmd.op == DP_PUSH || (cmd.op == DP_START && cmd.req == REQ_PUSH &&
		    count_q != CntW'(DEPTH))) begin
			step_mem[wr_slot] <= in_step;
			amt_mem[wr_slot]  <= in_amount;
		end else if (cmd.op == DP_WALK && ph_q && req_q == REQ_WITHDRAW && !walk_end &&
		             rd_amt_q > left_q) begin
			amt_mem[rd_slot] <= rd_amt_q - left_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else if (cmd.op == DP_START) begin
			case (cmd.req)
				REQ_PUSH:  if (count_q != CntW'(DEPTH)) count_q <= count_q + 1'b1;
				REQ_CLEAR: begin
					count_q  <= '0;
					oldest_q <= '0;
				end
				default: ;
			endcase
		end else if (cmd.op == DP_WALK && ph_q && req_q == REQ_WITHDRAW && !walk_end &&
		             rd_amt_q <= left_q) begin
			oldest_q <= (oldest_q == IdxW'(DEPTH-1)) ? '0 : oldest_q + 1'b1;
			count_q  <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START: begin
				req_q        <= cmd.req;
				arg_step_q   <= in_step;
				left_q       <= in_amount;
				want_q       <= in_amount;
				k_q          <= '0;
				acc_q        <= '0;
				tot_q        <= '0;
				older_q      <= '0;
				first_ok_q   <= 1'b0;
				ph_q         <= 1'b0;
				push_dropped <= (cmd.req == REQ_PUSH) && (count_q == CntW'(DEPTH));
				amount_taken <= '0;
				average_age  <= '0;
				amount_older <= '0;
			end
			DP_WALK: begin
				ph_q <= !ph_q;
				if (ph_q) begin
					if (walk_end) begin
						if (req_q == REQ_WITHDRAW) amount_taken <= want_q - left_q;
						if (req_q == REQ_OLDER)    amount_older <= first_ok_q ? older_q : '0;
					end else if (req_q == REQ_WITHDRAW) begin
						left_q <= (rd_amt_q > left_q) ? '0 : left_q - rd_amt_q;
					end else begin
						k_q <= k_q + 1'b1;
						if (req_q == REQ_AVERAGE) begin
							tot_q <= tot_q + TotW'(rd_amt_q);
							acc_q <= age_neg ? acc_q - AccW'(prod) : acc_q + AccW'(prod);
						end else begin
							if (k_q == '0) first_ok_q <= !(arg_step_q < rd_step_q);
							if (rd_step_q <= arg_step_q)
								older_q <= older_sat ? {OlderW{1'b1}} : older_sum[OlderW-1:0];
						end
					end
				end
			end
			DP_DIV_START: begin
				neg_q  <= acc_q[AccW-1];
				num_q  <= NumW'({acc_mag, 16'd0});
				rem_q  <= '0;
				dcnt_q <= DivCntW'(NumW);
			end
			DP_DIV: begin
				if (dcnt_q != '0) begin
					dcnt_q <= dcnt_q - 1'b1;
					if (!rem_sub[NumW]) begin
						rem_q <= rem_sub;
						num_q <= {num_q[NumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[NumW-2:0], 1'b0};
					end
				end else begin
					average_age <= neg_q ? (~q_trunc + 1'b1) : q_trunc;
				end
			end
			default: ;
		endcase
	end

	assign lots_held = count_q;
endmodule

@@ hw/rtl/lfwe_checker.sv @@
// ----------------------------------------------------------------------------
// lfwe_checker
// Port-level checks on the lot queue engine.
// ----------------------------------------------------------------------------
module lfwe_port_checks (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);
	// one transaction at a time: no input while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken with result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[125:121] <= 5'd16) else $error("lot count out of range");
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[126] |-> m_tdata[125:121] == 5'd16)
		else $error("drop with room left");
endmodule

bind lot_fifo_withdraw_engine lfwe_port_checks u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
